// File: rtl/core/segment_allocator_fit_coalesce_core_assert.svh
// Assertion macros shared by the allocator RTL.
// The macros expect signals named clk and rst_n in the including scope.
`ifndef SEGMENT_ALLOCATOR_FIT_COALESCE_CORE_ASSERT_SVH
`define SEGMENT_ALLOCATOR_FIT_COALESCE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SAFCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SAFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sgalloc_pkg.sv
`default_nettype none

package sgalloc_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADSIZE = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_UNUSED  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic       REG_POOL_SIZE  = 1'b0;
    localparam logic       REG_FIT_POLICY = 1'b1;

    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic       REQ_FREE = 1'b1;

    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_ROTATE  = 3'd1,
        OP_RESTART = 3'd2,
        OP_WRITE   = 3'd3,
        OP_SPLIT   = 3'd4,
        OP_MERGE   = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     two;   // merge drops two entries instead of one
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_MOD   = 4'b0100,
        S_STATS = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/sgalloc_cell.sv
`default_nettype none

module sgalloc_cell #(
    parameter int J         = 0,
    parameter int IDX_W     = 6,
    parameter int ADDR_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sgalloc_pkg::cell_ctrl_t    ctrl,
    input  wire logic [IDX_W-1:0]           pos,
    input  wire logic [2*ADDR_BITS+17:0]    new_a,
    input  wire logic [2*ADDR_BITS+17:0]    new_b,
    input  wire logic [2*ADDR_BITS+17:0]    left,
    input  wire logic [2*ADDR_BITS+17:0]    right1,
    input  wire logic [2*ADDR_BITS+17:0]    right2,
    input  wire logic [2*ADDR_BITS+17:0]    rot_in,
    output logic      [2*ADDR_BITS+17:0]    ent
);

    localparam int ENTRY_W = 2 * ADDR_BITS + 18;
    localparam logic [IDX_W:0] JV = (IDX_W + 1)'(J);
    // Cell 0 starts as one free segment covering the default pool.
    localparam logic [ENTRY_W-1:0] RST_VAL = (J == 0) ?
        {1'b1, 1'b0, 16'd0, ADDR_BITS'(16'hFFFF), {ADDR_BITS{1'b0}}} : '0;

    logic [ENTRY_W-1:0] ent_reg;
    logic [ENTRY_W-1:0] ent_next;
    logic [IDX_W:0]     p_x;
    logic [IDX_W:0]     p1_x;
    logic               at_p;
    logic               at_p1;
    logic               below_p;

    assign p_x     = {1'b0, pos};
    assign p1_x    = p_x + (IDX_W + 1)'(1);
    assign at_p    = (JV == p_x);
    assign at_p1   = (JV == p1_x);
    assign below_p = (JV < p_x);

    always_comb
    begin
        ent_next = ent_reg;
        case (ctrl.op)
            sgalloc_pkg::OP_HOLD:    ent_next = ent_reg;
            sgalloc_pkg::OP_ROTATE:  ent_next = rot_in;
            sgalloc_pkg::OP_RESTART: ent_next = (J == 0) ? new_a : '0;
            sgalloc_pkg::OP_WRITE:   ent_next = at_p ? new_a : ent_reg;
            sgalloc_pkg::OP_SPLIT:
            begin
                if (below_p)
                    ent_next = ent_reg;
                else if (at_p)
                    ent_next = new_a;
                else if (at_p1)
                    ent_next = new_b;
                else
                    ent_next = left;
            end
            sgalloc_pkg::OP_MERGE:
            begin
                if (below_p)
                    ent_next = ent_reg;
                else if (at_p)
                    ent_next = new_a;
                else
                    ent_next = ctrl.two ? right2 : right1;
            end
            default: ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= RST_VAL;
        else
            ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

`default_nettype wire

// File: rtl/core/sgalloc_chain.sv
`default_nettype none

module sgalloc_chain #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sgalloc_pkg::cell_ctrl_t            ctrl,
    input  wire logic [$clog2(MAX_SEGMENTS)-1:0]    pos,
    input  wire logic [2*ADDR_BITS+17:0]            new_a,
    input  wire logic [2*ADDR_BITS+17:0]            new_b,
    output logic      [2*ADDR_BITS+17:0]            head
);

    localparam int ENTRY_W = 2 * ADDR_BITS + 18;
    localparam int IDX_W   = $clog2(MAX_SEGMENTS);

    logic [ENTRY_W-1:0] ent [MAX_SEGMENTS];

    // Rotation moves every entry one cell toward cell 0, with cell 0 wrapping to the
    // far end; split and merge shift entries, with zeros entering at the far end on a merge.
    for (genvar j = 0; j < MAX_SEGMENTS; j++)
    begin : g_cell
        logic [ENTRY_W-1:0] left_w;
        logic [ENTRY_W-1:0] right1_w;
        logic [ENTRY_W-1:0] right2_w;

        if (j > 0)
        begin : g_left
            assign left_w = ent[j-1];
        end
        else
        begin : g_left0
            assign left_w = '0;
        end

        if (j + 1 < MAX_SEGMENTS)
        begin : g_r1
            assign right1_w = ent[j+1];
        end
        else
        begin : g_r1e
            assign right1_w = '0;
        end

        if (j + 2 < MAX_SEGMENTS)
        begin : g_r2
            assign right2_w = ent[j+2];
        end
        else
        begin : g_r2e
            assign right2_w = '0;
        end

        sgalloc_cell #(
            .J         (j),
            .IDX_W     (IDX_W),
            .ADDR_BITS (ADDR_BITS)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .pos    (pos),
            .new_a  (new_a),
            .new_b  (new_b),
            .left   (left_w),
            .right1 (right1_w),
            .right2 (right2_w),
            .rot_in (ent[(j + 1) % MAX_SEGMENTS]),
            .ent    (ent[j])
        );
    end

    assign head = ent[0];

endmodule

`default_nettype wire

// File: rtl/core/segment_allocator_fit_coalesce_core.sv
// Sequence: after the input transfer, a scan pass rotates the segment cell ring once,
// the table update follows, and a statistics pass rotates the ring once more before
// the result is valid; an allocate of size zero skips the scan and the update.
// Throughput: one request at a time; the next input transfer is taken once the result
// transfer has completed.
// Reset: the table holds one free segment of 65535, ID counter 1, tallies zero,
// first fit. A pool size write restarts the table and the ID counter.
`default_nettype none

`include "segment_allocator_fit_coalesce_core_assert.svh"

module segment_allocator_fit_coalesce_core #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [31:0]    s_axis_tdata,   // alloc_size, free_address
    input  wire logic [0:0]     s_axis_tuser,   // req_type
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // granted_address, granted_id, free_total, largest_free, success_count,
    // failure_count
    output logic      [127:0]   m_axis_tdata,
    output logic      [2:0]     m_axis_tuser,   // status
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [15:0]    cfg_data
);

    localparam int ENTRY_W = 2 * ADDR_BITS + 18;
    localparam int IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);

    sgalloc_pkg::state_t     state_reg;
    sgalloc_pkg::state_t     state_next;
    sgalloc_pkg::cell_ctrl_t ctrl;

    logic [IDX_W-1:0]     pos;
    logic [ENTRY_W-1:0]   new_a;
    logic [ENTRY_W-1:0]   new_b;
    logic [ENTRY_W-1:0]   head;

    logic                 h_valid;
    logic                 h_used;
    logic [ADDR_BITS-1:0] h_size;
    logic [ADDR_BITS-1:0] h_start;

    logic [IDX_W-1:0]     scan_cnt_reg;
    logic                 scan_last;
    logic                 req_free_reg;
    logic [ADDR_BITS-1:0] req_size_reg;
    logic [15:0]          req_addr_reg;
    logic [1:0]           fit_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [ADDR_BITS-1:0] pick_size_reg;
    logic [ADDR_BITS-1:0] pick_start_reg;
    logic                 prev_free_reg;
    logic [ADDR_BITS-1:0] prev_size_reg;
    logic [ADDR_BITS-1:0] prev_start_reg;
    logic                 mprev_free_reg;
    logic [ADDR_BITS-1:0] mprev_size_reg;
    logic [ADDR_BITS-1:0] mprev_start_reg;
    logic                 want_next_reg;
    logic                 next_free_reg;
    logic [ADDR_BITS-1:0] next_size_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [15:0]          id_reg;
    logic [31:0]          ok_reg;
    logic [31:0]          fail_reg;
    logic [2:0]           status_reg;
    logic [15:0]          gaddr_reg;
    logic [15:0]          gid_reg;
    logic [15:0]          total_reg;
    logic [ADDR_BITS-1:0] largest_reg;
    logic                 out_valid_reg;

    logic                 in_xfer;
    logic [ADDR_BITS-1:0] in_size;
    logic                 cand;
    logic                 take;
    logic                 addr_hit;
    logic                 restart;

    sgalloc_pkg::cell_ctrl_t mod_ctrl;
    logic [IDX_W-1:0]     mod_pos;
    logic [ENTRY_W-1:0]   mod_a;
    logic [ENTRY_W-1:0]   mod_b;
    logic [2:0]           mod_status;
    logic                 mod_grant;

    sgalloc_chain #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .pos   (pos),
        .new_a (new_a),
        .new_b (new_b),
        .head  (head)
    );

    assign h_start = head[ADDR_BITS-1:0];
    assign h_size  = head[2*ADDR_BITS-1:ADDR_BITS];
    assign h_used  = head[ENTRY_W-2];
    assign h_valid = head[ENTRY_W-1];

    assign s_axis_tready = (state_reg == sgalloc_pkg::S_IDLE) && !out_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_size       = ADDR_BITS'(s_axis_tdata[15:0]);
    assign scan_last     = (scan_cnt_reg == IDX_W'(MAX_SEGMENTS - 1));
    assign restart       = cfg_we && (cfg_index == sgalloc_pkg::REG_POOL_SIZE);

    assign cand = h_valid && !h_used && (h_size >= req_size_reg);
    always_comb
    begin
        take = 1'b0;
        if (cand)
        begin
            if (!found_reg)
                take = 1'b1;
            else if (fit_reg == sgalloc_pkg::FIT_BEST)
                take = (h_size < pick_size_reg);
            else if (fit_reg == sgalloc_pkg::FIT_WORST)
                take = (h_size > pick_size_reg);
        end
    end
    assign addr_hit = !found_reg && h_valid && h_used
                      && (32'(h_start) == 32'(req_addr_reg));

    // Table update chosen after the scan.
    always_comb
    begin
        mod_ctrl.op  = sgalloc_pkg::OP_HOLD;
        mod_ctrl.two = 1'b0;
        mod_pos      = pick_reg;
        mod_a        = {1'b1, 1'b1, id_reg, req_size_reg, pick_start_reg};
        mod_b        = {1'b1, 1'b0, 16'd0, pick_size_reg - req_size_reg,
                        pick_start_reg + req_size_reg};
        mod_status   = sgalloc_pkg::ST_OK;
        mod_grant    = 1'b0;
        if (!req_free_reg)
        begin
            if (!found_reg)
                mod_status = sgalloc_pkg::ST_NOFIT;
            else if (pick_size_reg != req_size_reg)
            begin
                if (count_reg >= CNT_W'(MAX_SEGMENTS))
                    mod_status = sgalloc_pkg::ST_FULL;
                else
                begin
                    mod_ctrl.op = sgalloc_pkg::OP_SPLIT;
                    mod_grant   = 1'b1;
                end
            end
            else
            begin
                mod_ctrl.op = sgalloc_pkg::OP_WRITE;
                mod_grant   = 1'b1;
            end
        end
        else
        begin
            if (!found_reg)
                mod_status = sgalloc_pkg::ST_UNUSED;
            else if (mprev_free_reg)
            begin
                mod_ctrl.op  = sgalloc_pkg::OP_MERGE;
                mod_ctrl.two = next_free_reg;
                mod_pos      = pick_reg - IDX_W'(1);
                mod_a        = {1'b1, 1'b0, 16'd0,
                                mprev_size_reg + pick_size_reg
                                + (next_free_reg ? next_size_reg : '0),
                                mprev_start_reg};
            end
            else if (next_free_reg)
            begin
                mod_ctrl.op = sgalloc_pkg::OP_MERGE;
                mod_a       = {1'b1, 1'b0, 16'd0, pick_size_reg + next_size_reg,
                               pick_start_reg};
            end
            else
            begin
                mod_ctrl.op = sgalloc_pkg::OP_WRITE;
                mod_a       = {1'b1, 1'b0, 16'd0, pick_size_reg, pick_start_reg};
            end
        end
    end

    always_comb
    begin
        ctrl.op  = sgalloc_pkg::OP_HOLD;
        ctrl.two = 1'b0;
        pos      = mod_pos;
        new_a    = mod_a;
        new_b    = mod_b;
        if (restart)
        begin
            ctrl.op = sgalloc_pkg::OP_RESTART;
            new_a   = {1'b1, 1'b0, 16'd0, ADDR_BITS'(cfg_data), {ADDR_BITS{1'b0}}};
        end
        else
        begin
            case (state_reg)
                sgalloc_pkg::S_SCAN:  ctrl.op = sgalloc_pkg::OP_ROTATE;
                sgalloc_pkg::S_STATS: ctrl.op = sgalloc_pkg::OP_ROTATE;
                sgalloc_pkg::S_MOD:   ctrl    = mod_ctrl;
                default:              ctrl.op = sgalloc_pkg::OP_HOLD;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sgalloc_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser[0] != sgalloc_pkg::REQ_FREE && in_size == '0)
                        state_next = sgalloc_pkg::S_STATS;
                    else
                        state_next = sgalloc_pkg::S_SCAN;
                end
            end
            sgalloc_pkg::S_SCAN:
                if (scan_last)
                    state_next = sgalloc_pkg::S_MOD;
            sgalloc_pkg::S_MOD:   state_next = sgalloc_pkg::S_STATS;
            sgalloc_pkg::S_STATS:
                if (scan_last)
                    state_next = sgalloc_pkg::S_IDLE;
            default: state_next = sgalloc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgalloc_pkg::S_IDLE;
            scan_cnt_reg  <= '0;
            fit_reg       <= '0;
            count_reg     <= CNT_W'(1);
            id_reg        <= 16'd1;
            ok_reg        <= '0;
            fail_reg      <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            want_next_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index == sgalloc_pkg::REG_FIT_POLICY)
                fit_reg <= cfg_data[1:0];
            if (restart)
            begin
                count_reg <= CNT_W'(1);
                id_reg    <= 16'd1;
            end
            case (state_reg)
                sgalloc_pkg::S_IDLE:
                begin
                    scan_cnt_reg  <= '0;
                    found_reg     <= 1'b0;
                    want_next_reg <= 1'b0;
                    if (in_xfer)
                    begin
                        req_free_reg   <= (s_axis_tuser[0] == sgalloc_pkg::REQ_FREE);
                        req_size_reg   <= in_size;
                        req_addr_reg   <= s_axis_tdata[31:16];
                        prev_free_reg  <= 1'b0;
                        mprev_free_reg <= 1'b0;
                        next_free_reg  <= 1'b0;
                        gaddr_reg      <= '0;
                        gid_reg        <= '0;
                        total_reg      <= '0;
                        largest_reg    <= '0;
                        status_reg     <= sgalloc_pkg::ST_BADSIZE;
                        if (s_axis_tuser[0] != sgalloc_pkg::REQ_FREE && in_size == '0
                            && fail_reg != '1)
                            fail_reg <= fail_reg + 32'd1;
                    end
                end
                sgalloc_pkg::S_SCAN:
                begin
                    scan_cnt_reg   <= scan_cnt_reg + IDX_W'(1);
                    prev_free_reg  <= h_valid && !h_used;
                    prev_size_reg  <= h_size;
                    prev_start_reg <= h_start;
                    want_next_reg  <= 1'b0;
                    if (want_next_reg)
                    begin
                        next_free_reg <= h_valid && !h_used;
                        next_size_reg <= h_size;
                    end
                    if (!req_free_reg && take)
                    begin
                        found_reg      <= 1'b1;
                        pick_reg       <= scan_cnt_reg;
                        pick_size_reg  <= h_size;
                        pick_start_reg <= h_start;
                    end
                    // First fit keeps the lowest match, as does the undefined policy code.
                    if (req_free_reg && addr_hit)
                    begin
                        found_reg       <= 1'b1;
                        pick_reg        <= scan_cnt_reg;
                        pick_size_reg   <= h_size;
                        pick_start_reg  <= h_start;
                        mprev_free_reg  <= prev_free_reg;
                        mprev_size_reg  <= prev_size_reg;
                        mprev_start_reg <= prev_start_reg;
                        want_next_reg   <= 1'b1;
                    end
                end
                sgalloc_pkg::S_MOD:
                begin
                    scan_cnt_reg <= '0;
                    status_reg   <= mod_status;
                    if (mod_ctrl.op == sgalloc_pkg::OP_SPLIT)
                        count_reg <= count_reg + CNT_W'(1);
                    else if (mod_ctrl.op == sgalloc_pkg::OP_MERGE)
                        count_reg <= count_reg - (mod_ctrl.two ? CNT_W'(2) : CNT_W'(1));
                    if (mod_grant)
                    begin
                        gaddr_reg <= 16'(pick_start_reg);
                        gid_reg   <= id_reg;
                        id_reg    <= (id_reg == 16'hFFFF) ? 16'd1 : id_reg + 16'd1;
                        if (ok_reg != '1)
                            ok_reg <= ok_reg + 32'd1;
                    end
                    else if (!req_free_reg && fail_reg != '1)
                        fail_reg <= fail_reg + 32'd1;
                end
                sgalloc_pkg::S_STATS:
                begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                    if (h_valid && !h_used)
                    begin
                        total_reg <= total_reg + 16'(h_size);
                        if (h_size > largest_reg)
                            largest_reg <= h_size;
                    end
                    if (scan_last)
                        out_valid_reg <= 1'b1;
                end
                default: scan_cnt_reg <= '0;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {fail_reg, ok_reg, 16'(largest_reg), total_reg, gid_reg, gaddr_reg};

    `SAFCC_ASSERT_NOW(a_count_range, 1'b1,
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(MAX_SEGMENTS)),
        "segment count out of range")
    `SAFCC_ASSERT_NOW(a_split_room, ctrl.op == sgalloc_pkg::OP_SPLIT,
        count_reg < CNT_W'(MAX_SEGMENTS), "split with a full table")
    `SAFCC_ASSERT_NEXT(a_result_after_stats,
        (state_reg == sgalloc_pkg::S_STATS) && scan_last,
        m_axis_tvalid && (state_reg == sgalloc_pkg::S_IDLE),
        "result not presented after statistics pass")
    `SAFCC_ASSERT_NOW(a_grant_nonzero_id, m_axis_tvalid && (m_axis_tuser == sgalloc_pkg::ST_OK)
        && !req_free_reg, gid_reg != 16'd0, "granted ID is zero")

endmodule

`default_nettype wire
